@@ hdl/mvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// mvt_pkg: types, constants and helpers for the matrix_vector_transform block.
// No dependencies; imported by every module of the block.

package mvt_pkg;

  // Fixed-point format: signed Q(31-FracBits).FracBits
  localparam int unsigned FracBits = 16;
  localparam int unsigned QW       = 32;
  localparam int unsigned Dim      = 4;
  localparam int unsigned ProdW    = 2 * QW;     // full product
  localparam int unsigned PairW    = ProdW + 1;  // sum of two products
  localparam int unsigned SumW     = ProdW + 2;  // sum of four products

  typedef logic signed [QW-1:0]    q_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [PairW-1:0] pair_t;
  typedef logic signed [SumW-1:0]  sum_t;

  typedef q_t [Dim-1:0]            vec_t;
  typedef vec_t [Dim-1:0]          mat_t;    // [row][col]
  typedef prod_t [Dim-1:0][Dim-1:0] prods_t; // [result elem][term]

  localparam q_t QOne = q_t'(1 << FracBits);
  localparam q_t QMax = 32'sh7fff_ffff;
  localparam q_t QMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ModeLoad   = 2'd0,
    ModeMatVec = 2'd1,
    ModeVecMat = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] row_number;
    q_t         elem_a;
    q_t         elem_b;
    q_t         elem_c;
    q_t         elem_d;
  } in_item_t;

  typedef struct packed {
    q_t   res_a;
    q_t   res_b;
    q_t   res_c;
    q_t   res_d;
    logic saturated;
  } out_item_t;

  // Operands of one multiply transaction: m is already oriented so that
  // result element i is sum over j of m[i][j] * v[j].
  typedef struct packed {
    mat_t m;
    vec_t v;
  } opnd_t;

  function automatic mat_t identity_mat();
    mat_t r;
    for (int i = 0; i < Dim; i++) begin
      for (int j = 0; j < Dim; j++) begin
        r[i][j] = (i == j) ? QOne : '0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/mvt_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// mvt_matrix: matrix store and operand capture stage (pipeline stage 1).
// Depends on mvt_pkg.

module mvt_matrix (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mvt_pkg::in_item_t in_data_i,
  output logic             s1_valid_o,
  input  logic             s1_ready_i,
  output mvt_pkg::opnd_t   s1_data_o
);
  import mvt_pkg::*;

  mat_t  matrix_q, matrix_d;
  logic  valid_q, valid_d;
  opnd_t opnd_q, opnd_d;
  logic  accept, is_load, is_mult, transpose;

  always_comb begin
    is_load   = 1'b0;
    is_mult   = 1'b0;
    transpose = 1'b0;
    case (in_data_i.mode)
      ModeLoad:   is_load = 1'b1;
      ModeMatVec: is_mult = 1'b1;
      ModeVecMat: begin
        is_mult   = 1'b1;
        transpose = 1'b1;
      end
      default: ; // unused code: dropped
    endcase
  end

  assign in_ready_o = !valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    matrix_d = matrix_q;
    if (accept && is_load) begin
      matrix_d[in_data_i.row_number][0] = in_data_i.elem_a;
      matrix_d[in_data_i.row_number][1] = in_data_i.elem_b;
      matrix_d[in_data_i.row_number][2] = in_data_i.elem_c;
      matrix_d[in_data_i.row_number][3] = in_data_i.elem_d;
    end
  end

  // Operands are taken from the matrix as it stands at acceptance, so a
  // later row load never reaches a transaction already in flight.
  always_comb begin
    opnd_d.v[0] = in_data_i.elem_a;
    opnd_d.v[1] = in_data_i.elem_b;
    opnd_d.v[2] = in_data_i.elem_c;
    opnd_d.v[3] = in_data_i.elem_d;
    for (int i = 0; i < Dim; i++) begin
      for (int j = 0; j < Dim; j++) begin
        opnd_d.m[i][j] = transpose ? matrix_q[j][i] : matrix_q[i][j];
      end
    end
  end

  assign valid_d = in_ready_o ? (accept && is_mult) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= identity_mat();
      valid_q  <= 1'b0;
    end else begin
      matrix_q <= matrix_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_mult) begin
      opnd_q <= opnd_d;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_data_o  = opnd_q;

  // Row load lands in the store
  a_row_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_load |=>
      matrix_q[$past(in_data_i.row_number)][0] == $past(in_data_i.elem_a) &&
      matrix_q[$past(in_data_i.row_number)][3] == $past(in_data_i.elem_d))
    else $error("row load not stored");

  // Multiply transaction enters stage 1
  a_mult_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_mult |=> valid_q)
    else $error("accepted multiply missing in stage 1");

endmodule

`default_nettype wire

@@ hdl/mvt_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// mvt_mul: sixteen 32x32 signed multipliers, registered (pipeline stage 2).
// Depends on mvt_pkg.

module mvt_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s1_valid_i,
  output logic           s1_ready_o,
  input  mvt_pkg::opnd_t s1_data_i,
  output logic           s2_valid_o,
  input  logic           s2_ready_i,
  output mvt_pkg::prods_t s2_data_o
);
  import mvt_pkg::*;

  logic   valid_q, valid_d;
  prods_t prods_q, prods_d;

  assign s1_ready_o = !valid_q || s2_ready_i;
  assign valid_d    = s1_ready_o ? s1_valid_i : valid_q;

  always_comb begin
    for (int i = 0; i < Dim; i++) begin
      for (int j = 0; j < Dim; j++) begin
        prods_d[i][j] = prod_t'($signed(s1_data_i.m[i][j])) *
                        prod_t'($signed(s1_data_i.v[j]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o && s1_valid_i) begin
      prods_q <= prods_d;
    end
  end

  assign s2_valid_o = valid_q;
  assign s2_data_o  = prods_q;

endmodule

`default_nettype wire

@@ hdl/mvt_reduce.sv @@
`timescale 1ns / 1ps
`default_nettype none
// mvt_reduce: pair sums, final sums, shift and saturation (stages 3 to 5).
// Depends on mvt_pkg; stage 5 is the block's output register.

module mvt_reduce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s2_valid_i,
  output logic              s2_ready_o,
  input  mvt_pkg::prods_t   s2_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mvt_pkg::out_item_t out_data_o
);
  import mvt_pkg::*;

  logic v3_q, v4_q, v5_q;
  logic r3, r4, r5;
  pair_t [Dim-1:0][1:0] pair_q, pair_d;
  sum_t  [Dim-1:0]      sum_q, sum_d;
  sum_t  [Dim-1:0]      shifted;
  q_t    [Dim-1:0]      res_d;
  logic  [Dim-1:0]      sat_d;
  out_item_t            out_q, out_d;

  assign r5         = !v5_q || out_ready_i;
  assign r4         = !v4_q || r5;
  assign r3         = !v3_q || r4;
  assign s2_ready_o = r3;

  always_comb begin
    for (int i = 0; i < Dim; i++) begin
      pair_d[i][0] = pair_t'(s2_data_i[i][0]) + pair_t'(s2_data_i[i][1]);
      pair_d[i][1] = pair_t'(s2_data_i[i][2]) + pair_t'(s2_data_i[i][3]);
      sum_d[i]     = sum_t'(pair_q[i][0]) + sum_t'(pair_q[i][1]);
    end
  end

  // Floor shift of the exact sum, then clamp to 32-bit range
  always_comb begin
    for (int i = 0; i < Dim; i++) begin
      shifted[i] = sum_q[i] >>> FracBits;
      if (shifted[i] > sum_t'(QMax)) begin
        res_d[i] = QMax;
        sat_d[i] = 1'b1;
      end else if (shifted[i] < sum_t'(QMin)) begin
        res_d[i] = QMin;
        sat_d[i] = 1'b1;
      end else begin
        res_d[i] = shifted[i][QW-1:0];
        sat_d[i] = 1'b0;
      end
    end
    out_d.res_a     = res_d[0];
    out_d.res_b     = res_d[1];
    out_d.res_c     = res_d[2];
    out_d.res_d     = res_d[3];
    out_d.saturated = |sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r3) v3_q <= s2_valid_i;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && s2_valid_i) pair_q <= pair_d;
    if (r4 && v3_q)       sum_q  <= sum_d;
    if (r5 && v4_q)       out_q  <= out_d;
  end

  assign out_valid_o = v5_q;
  assign out_data_o  = out_q;

  // Flag set only if some element sits at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && out_q.res_a != QMax && out_q.res_a != QMin &&
    out_q.res_b != QMax && out_q.res_b != QMin &&
    out_q.res_c != QMax && out_q.res_c != QMin &&
    out_q.res_d != QMax && out_q.res_d != QMin |-> !out_q.saturated)
    else $error("saturated flag without clamped element");

  // Stage 4 moves into the output register when it is free
  a_s4_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && r5 |=> v5_q)
    else $error("stage 4 transaction lost");

endmodule

`default_nettype wire

@@ hdl/matrix_vector_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// matrix_vector_transform: top level of the Q16.16 4x4 matrix transform unit.
// Depends on mvt_pkg, mvt_matrix, mvt_mul and mvt_reduce.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------
//   input   | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//   output  | out_valid_o / out_ready_i | out_data_o (out_item_t)
//
// Throughput: one transaction per cycle; every stage takes a new one each
// cycle while its successor moves on.
// Stages from acceptance to out_valid_o: operand capture, multiply, pair add,
// final add, shift/saturate output register.
// A row load updates the store at acceptance and is seen by the very next
// transaction; loads and unused mode codes produce no output transaction.
// Reset: store returns to identity, all pipeline stages empty.
// Stalls: a stage holds while its successor is full and stalled; empty
// stages keep accepting, so bubbles close up behind a stalled output.

module matrix_vector_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mvt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mvt_pkg::out_item_t out_data_o
);
  import mvt_pkg::*;

  // Stage 1: operands as seen at acceptance
  logic   s1_valid, s1_ready;
  opnd_t  s1_data;
  // Stage 2: sixteen full-width products
  logic   s2_valid, s2_ready;
  prods_t s2_data;

  mvt_matrix u_matrix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_data_o  (s1_data)
  );

  mvt_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_data_i  (s1_data),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_data_o  (s2_data)
  );

  // Stages 3-5; the last one is the output register
  mvt_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .s2_ready_o  (s2_ready),
    .s2_data_i   (s2_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ test/matrix_vector_transform_tb.sv @@
`timescale 1ns / 1ps
// matrix_vector_transform_tb: self-checking bench for the Q16.16 4x4 transform unit.
// Depends on mvt_pkg and matrix_vector_transform; predicts every output transaction
// from a local copy of the matrix and checks results in order.

module matrix_vector_transform_tb;
  import mvt_pkg::*;

  // Mode code the block must ignore (not part of mode_e)
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam int unsigned DrainCycles = 30;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned RandItems   = 550;
  localparam int unsigned CalmItems   = 120;  // last input transactions with no idling
  localparam int unsigned CalmResults = 60;   // last output transactions with no stalls

  typedef logic signed [63:0] wide_t;
  typedef logic signed [65:0] acc_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  matrix_vector_transform u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction: local matrix [row][col], updated in transaction order
  // ---------------------------------------------------------------------------
  q_t        shadow_mat [4][4];
  in_item_t  item_backlog [$];     // stimulus not yet presented
  out_item_t transformed_q [$];    // predicted output transactions, oldest first

  int unsigned total_items;
  int unsigned total_results;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned errors;

  // Exact sum of four full products, floor-shifted, clamped to 32 bits.
  function automatic q_t dot4(input q_t x [4], input q_t y [4], inout logic clamped);
    acc_t  acc;
    wide_t p;
    acc_t  shifted;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      p   = x[k] * y[k];
      acc = acc + p;
    end
    shifted = acc >>> FracBits;
    if (shifted > acc_t'(QMax)) begin
      clamped = 1'b1;
      return QMax;
    end else if (shifted < acc_t'(QMin)) begin
      clamped = 1'b1;
      return QMin;
    end
    return q_t'(shifted);
  endfunction

  task automatic transform_item(input in_item_t it);
    q_t        v [4];
    q_t        lane [4];
    q_t        res [4];
    logic      clamped;
    out_item_t r;
    v[0] = it.elem_a;
    v[1] = it.elem_b;
    v[2] = it.elem_c;
    v[3] = it.elem_d;
    clamped = 1'b0;
    case (it.mode)
      ModeLoad: begin
        for (int c = 0; c < 4; c++) shadow_mat[it.row_number][c] = v[c];
      end
      ModeMatVec, ModeVecMat: begin
        for (int i = 0; i < 4; i++) begin
          // mat*vec uses row i, vec*mat uses column i
          for (int j = 0; j < 4; j++) begin
            lane[j] = (it.mode == ModeMatVec) ? shadow_mat[i][j] : shadow_mat[j][i];
          end
          res[i] = dot4(lane, v, clamped);
        end
        r.res_a     = res[0];
        r.res_b     = res[1];
        r.res_c     = res[2];
        r.res_d     = res[3];
        r.saturated = clamped;
        transformed_q.push_back(r);
      end
      default: ;  // unused mode: nothing happens
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_item(input logic [1:0] mode, input logic [1:0] row,
                                         input q_t a, input q_t b, input q_t c, input q_t d);
    in_item_t it;
    it.mode       = mode;
    it.row_number = row;
    it.elem_a     = a;
    it.elem_b     = b;
    it.elem_c     = c;
    it.elem_d     = d;
    return it;
  endfunction

  // Mostly small magnitudes so sums stay in range; some full-range and corner values.
  function automatic q_t rand_elem();
    int unsigned pick;
    q_t          e;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      e = q_t'($urandom_range(0, 32'h7_FFFF)) - q_t'(32'h4_0000);
    end else if (pick < 7) begin
      e = q_t'($urandom_range(0, 32'h1FF_FFFF)) - q_t'(32'h100_0000);
    end else if (pick < 9) begin
      e = q_t'($urandom());
    end else begin
      case ($urandom_range(0, 6))
        0: e = QMax;
        1: e = QMin;
        2: e = '0;
        3: e = -1;
        4: e = 1;
        5: e = QOne;
        default: e = -QOne;
      endcase
    end
    return e;
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] mode);
    return make_item(mode, 2'($urandom_range(0, 3)),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endfunction

  task automatic queue_item(input in_item_t it);
    item_backlog.push_back(it);
    if (it.mode == ModeMatVec || it.mode == ModeVecMat) total_results++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents backlog items, idles in random bursts
  // ---------------------------------------------------------------------------
  int unsigned gap_left;
  int unsigned send_level;   // 0: no gaps, 3: frequent gaps

  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic     v_next;
    in_item_t d_next;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      send_level = 1;
    end else begin
      v_next = in_valid;
      d_next = in_data;
      if (in_valid && in_ready) begin
        transform_item(in_data);
        n_accepted++;
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (n_accepted + CalmItems < total_items && send_level != 0 &&
                     $urandom_range(0, 7) < send_level) begin
          gap_left = $urandom_range(0, 10);  // idle burst of random length
        end else if (item_backlog.size() > 0) begin
          v_next = 1'b1;
          d_next = item_backlog.pop_front();
          if ($urandom_range(0, 39) == 0) send_level = $urandom_range(0, 3);
        end
      end
      in_valid <= v_next;
      in_data  <= d_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each output transaction, stalls in random bursts
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned stall_level;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic      r_next;
    out_item_t want;
    logic      bad;
    if (!rst_ni) begin
      out_ready   <= 1'b0;
      stall_left  = 0;
      stall_level = 1;
    end else begin
      if (out_valid && out_ready) begin
        if (transformed_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("%0t: unexpected result %h %h %h %h sat=%b", $realtime,
                     out_data.res_a, out_data.res_b, out_data.res_c, out_data.res_d,
                     out_data.saturated);
          end
        end else begin
          want = transformed_q.pop_front();
          bad  = (out_data.res_a !== want.res_a) || (out_data.res_b !== want.res_b) ||
                 (out_data.res_c !== want.res_c) || (out_data.res_d !== want.res_d) ||
                 (out_data.saturated !== want.saturated);
          if (bad) begin
            errors++;
            if (errors <= MaxReports) begin
              $display("%0t: result %0d mismatch", $realtime, n_checked);
              $display("  expected %h %h %h %h sat=%b", want.res_a, want.res_b,
                       want.res_c, want.res_d, want.saturated);
              $display("  actual   %h %h %h %h sat=%b", out_data.res_a, out_data.res_b,
                       out_data.res_c, out_data.res_d, out_data.saturated);
            end
          end
          n_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        r_next = 1'b0;
      end else if (n_checked + CalmResults < total_results && stall_level != 0 &&
                   $urandom_range(0, 7) < stall_level) begin
        stall_left = $urandom_range(0, 10);
        r_next     = 1'b0;
      end else begin
        r_next = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) stall_level = $urandom_range(0, 3);
      out_ready <= r_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int unsigned pick;
    total_items   = 0;
    total_results = 0;
    n_accepted    = 0;
    n_checked     = 0;
    errors        = 0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) shadow_mat[r][c] = (r == c) ? QOne : '0;
    end

    // Directed: identity pass-through at the extremes
    queue_item(make_item(ModeMatVec, 2'd2, QMax, QMin, '0, -1));
    queue_item(make_item(ModeVecMat, 2'd1, 1, -QOne, QMax, QMin));
    // unused mode must neither load nor answer
    queue_item(make_item(ModeUnused, 2'd0, QMax, QMax, QMax, QMax));
    queue_item(make_item(ModeMatVec, 2'd3, QOne, 32'sh0001_8000, -QOne, 32'sh7fff_0000));
    // extreme rows; row 2 holds the smallest step for the floor check
    queue_item(make_item(ModeLoad, 2'd0, QMax, QMax, QMax, QMax));
    queue_item(make_item(ModeLoad, 2'd1, QMin, QMin, QMin, QMin));
    queue_item(make_item(ModeLoad, 2'd2, 1, '0, '0, '0));
    queue_item(make_item(ModeLoad, 2'd3, QOne, -QOne, '0, QMin));
    // overflow both ways
    queue_item(make_item(ModeMatVec, 2'd0, QMax, QMax, QMax, QMax));
    queue_item(make_item(ModeMatVec, 2'd1, QMin, QMin, QMin, QMin));
    queue_item(make_item(ModeVecMat, 2'd2, QMin, QMax, '0, '0));
    queue_item(make_item(ModeVecMat, 2'd3, QMax, QMax, QMax, QMax));
    // negative product floors: 1 * -1 >> 16 is -1
    queue_item(make_item(ModeMatVec, 2'd0, -1, 5, 7, 9));
    queue_item(make_item(ModeUnused, 2'd2, '0, '0, '0, '0));
    queue_item(make_item(ModeMatVec, 2'd1, '0, '0, '0, '0));
    queue_item(make_item(ModeVecMat, 2'd0, -1, -1, -1, -1));
    // back to a well-scaled matrix before the random part
    queue_item(make_item(ModeLoad, 2'd0, QOne, '0, '0, '0));
    queue_item(make_item(ModeLoad, 2'd1, '0, QOne, '0, '0));
    queue_item(make_item(ModeLoad, 2'd2, '0, '0, -QOne, '0));
    queue_item(make_item(ModeLoad, 2'd3, 32'sh0000_8000, '0, '0, QOne));
    queue_item(make_item(ModeVecMat, 2'd1, QMax, QMin, QMax, QMin));

    // Random: mostly multiplies against a matrix that keeps changing
    for (int n = 0; n < RandItems; n++) begin
      pick = $urandom_range(0, 39);
      if (pick < 2) begin
        // full reload of the matrix
        for (int r = 0; r < 4; r++) begin
          queue_item(make_item(ModeLoad, 2'(r), rand_elem(), rand_elem(), rand_elem(),
                               rand_elem()));
        end
      end else if (pick < 10) begin
        queue_item(rand_item(ModeLoad));
      end else if (pick < 24) begin
        queue_item(rand_item(ModeMatVec));
      end else if (pick < 38) begin
        queue_item(rand_item(ModeVecMat));
      end else begin
        queue_item(rand_item(ModeUnused));
      end
    end
    total_items = item_backlog.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_backlog.size() != 0 || in_valid || transformed_q.size() != 0) begin
      @(posedge clk_i);
    end
    // catch any stray output after the last expected one
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0 && transformed_q.size() == 0) begin
      $display("matrix_vector_transform_tb: done, clean");
    end else begin
      $display("matrix_vector_transform_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("matrix_vector_transform_tb: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mvt_pkg.sv
hdl/mvt_matrix.sv
hdl/mvt_mul.sv
hdl/mvt_reduce.sv
hdl/matrix_vector_transform.sv
test/matrix_vector_transform_tb.sv
